FILE: design/drum_step_sequencer_assert.svh
// Assertion macros for the drum step sequencer.
// DSS_ASSERT checks an implication in the same cycle, DSS_ASSERT_NEXT in the cycle after.
`ifndef DRUM_STEP_SEQUENCER_ASSERT_SVH
`define DRUM_STEP_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DSS_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DSS_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/dss_pkg.sv
package dss_pkg;

    localparam int NUM_INSTRUMENTS = 16;
    localparam int NUM_STEPS       = 16;

    // physical grid: one word per column, two bits per instrument row
    localparam int GRID_ROWS = 16;
    localparam int GRID_COLS = 16;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int CELL_W    = 2;
    localparam int WORD_W    = CELL_W * GRID_ROWS;

    localparam logic [CELL_W-1:0] CELL_OFF    = 2'd0;
    localparam logic [CELL_W-1:0] CELL_ON     = 2'd1;
    localparam logic [CELL_W-1:0] CELL_ACCENT = 2'd2;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_START = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_SET   = 3'd3,
        MODE_CYCLE = 3'd4,
        MODE_CLEAR = 3'd5
    } t_mode;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUFFLE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_MS  = 2'd2;

    localparam int STEP_W  = 17;
    localparam int SHUF_W  = 9;
    localparam int SPM_W   = 8;
    localparam int CNT_W   = 18;
    localparam int DRIFT_W = 16;
    localparam int MASK_W  = 16;

    localparam logic [STEP_W-1:0] STEP_RESET = 17'd6000;
    localparam logic [SHUF_W-1:0] SHUF_RESET = 9'd0;
    localparam logic [SPM_W-1:0]  SPM_RESET  = 8'd48;

    localparam int SWING_NUM   = 338;
    localparam int SWING_SHIFT = 18;
    localparam int DRIFT_KEEP  = 21299;
    localparam int DRIFT_TAKE  = 11469;
    localparam int Q15_HALF    = 16384;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic              we;
        logic [COL_W-1:0]  addr;
        logic [WORD_W-1:0] word;
    } t_grid_wr;

endpackage

FILE: design/dss_mul.sv
module dss_mul
    import dss_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a * i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: design/dss_grid.sv
module dss_grid
    import dss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  t_grid_wr          i_wr,
    input  logic [COL_W-1:0]  i_rd_addr,
    output logic [WORD_W-1:0] o_rd_word
);

    logic [WORD_W-1:0]    r_mem [GRID_COLS];
    logic [WORD_W-1:0]    r_rd_data;
    logic [COL_W-1:0]     r_rd_addr;
    logic [GRID_COLS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.word;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    // a column never written since the last clear or reset reads as all off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_word = r_valid[r_rd_addr] ? r_rd_data : '0;

endmodule

FILE: design/drum_step_sequencer.sv
// Drum step sequencer: 16 instrument rows by 16 step columns of off/on/accent cells.
// Input channel i_valid/o_stall carries one item per sample tick or command
// (tick, start, stop, set cell, cycle cell, clear grid). Output channel
// o_valid/i_stall returns exactly one result per item: fired flag, trigger and
// accent masks of the fired column, the fired column, the addressed cell and the
// transport flag.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data), written
// only while the block is idle; that binds the user, the block does not enforce it.
// Timing: one item is in flight at a time. A non-firing item runs ST_RB1 (ST_ED1
// for edits) and ST_OUT; a firing tick runs ST_SW1, ST_SW2, ST_LOAD, ST_RB0, ST_RB1
// and ST_OUT, with ST_DR0 to ST_DR3 after ST_SW2 on drift columns. o_valid rises
// and o_stall drops at the same edge. The single registered multiplier, used once
// per product in the swing and drift chain, and the one-read-port grid set the pace.
// Reset (synchronous, i_rst_n low) stops the transport, clears the grid, zeroes
// the column and drift filter and loads the register defaults.
// A finished result waits in the output register while i_stall is high; the next
// item is accepted meanwhile but its result is held until the register frees.
`include "drum_step_sequencer_assert.svh"

module drum_step_sequencer
    import dss_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_mode,
    input  logic [ROW_W-1:0]            i_instrument,
    input  logic [COL_W-1:0]            i_step_index,
    input  logic [CELL_W-1:0]           i_cell_value,
    input  logic signed [DRIFT_W-1:0]   i_drift_random,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_fired,
    output logic [MASK_W-1:0]           o_trigger_mask,
    output logic [MASK_W-1:0]           o_accent_mask,
    output logic [COL_W-1:0]            o_fired_step,
    output logic [CELL_W-1:0]           o_cell_readback,
    output logic                        o_is_running,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SW1, ST_SW2, ST_DR0, ST_DR1, ST_DR2, ST_DR3,
        ST_LOAD, ST_RB0, ST_RB1, ST_ED1, ST_OUT
    } t_state;

    t_state r_state;

    logic [STEP_W-1:0]          r_step_len;
    logic [SHUF_W-1:0]          r_shuffle;
    logic [SPM_W-1:0]           r_spm;

    logic [CNT_W-1:0]           r_countdown;
    logic [COL_W-1:0]           r_column;
    logic                       r_run;
    logic signed [DRIFT_W-1:0]  r_drift_mem;

    logic [ROW_W-1:0]           r_inst;
    logic [COL_W-1:0]           r_col;
    logic [CELL_W-1:0]          r_val;
    logic signed [DRIFT_W-1:0]  r_target;
    logic                       r_edit_set;

    logic signed [19:0]         r_base;
    logic signed [31:0]         r_sum;
    logic signed [10:0]         r_dsamp;

    logic                       r_fired;
    logic [MASK_W-1:0]          r_trig;
    logic [MASK_W-1:0]          r_accm;
    logic [COL_W-1:0]           r_fstep;
    logic [CELL_W-1:0]          r_rdbk;

    logic                       r_out_valid;
    logic                       r_out_fired;
    logic [MASK_W-1:0]          r_out_trig;
    logic [MASK_W-1:0]          r_out_accm;
    logic [COL_W-1:0]           r_out_fstep;
    logic [CELL_W-1:0]          r_out_rdbk;
    logic                       r_out_run;

    logic                       accept;
    logic                       fire_now;
    logic                       addr_ok;
    logic [COL_W-1:0]           rd_addr;
    logic [WORD_W-1:0]          grid_word;
    logic [CELL_W-1:0]          rd_cell;
    logic [CELL_W-1:0]          n_cell;
    logic [WORD_W-1:0]          n_word;
    logic [MASK_W-1:0]          col_trig;
    logic [MASK_W-1:0]          col_accm;
    t_grid_wr                   grid_wr;
    logic                       grid_clear;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;

    logic [STEP_W-1:0]          swing;
    logic signed [31:0]         dr_sum;
    logic signed [31:0]         dr_shift;
    logic signed [16:0]         dr_m;
    logic signed [DRIFT_W-1:0]  n_drift_mem;
    logic signed [23:0]         dr_p;
    logic [23:0]                dr_mag;
    logic [24:0]                dr_rnd_full;
    logic [9:0]                 dr_rnd;
    logic signed [10:0]         n_dsamp;
    logic signed [19:0]         n_reload;
    logic [CNT_W-1:0]           n_countdown;
    logic [COL_W:0]             col_inc;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign fire_now = (i_mode == MODE_TICK) && r_run && (r_countdown <= CNT_W'(1));
    assign addr_ok  = ({1'b0, r_inst} < (ROW_W + 1)'(NUM_INSTRUMENTS)) &&
                      ({1'b0, r_col} < (COL_W + 1)'(NUM_STEPS));

    assign rd_addr    = (r_state == ST_IDLE) ? (fire_now ? r_column : i_step_index) : r_col;
    assign grid_clear = accept && (i_mode == MODE_CLEAR);

    dss_grid u_grid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (grid_clear),
        .i_wr      (grid_wr),
        .i_rd_addr (rd_addr),
        .o_rd_word (grid_word)
    );

    dss_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // cell edit and readback
    always_comb begin
        rd_cell = grid_word[{r_inst, 1'b0} +: CELL_W];
        if (r_edit_set) begin
            n_cell = (r_val > CELL_ACCENT) ? CELL_ACCENT : r_val;
        end else begin
            unique case (rd_cell)
                CELL_OFF: n_cell = CELL_ON;
                CELL_ON:  n_cell = CELL_ACCENT;
                default:  n_cell = CELL_OFF;
            endcase
        end
        n_word = grid_word;
        n_word[{r_inst, 1'b0} +: CELL_W] = n_cell;
        grid_wr.we   = (r_state == ST_ED1) && addr_ok;
        grid_wr.addr = r_col;
        grid_wr.word = n_word;
    end

    // masks of the fired column
    always_comb begin
        col_trig = '0;
        col_accm = '0;
        for (int i = 0; i < GRID_ROWS; i++) begin
            if (i < NUM_INSTRUMENTS) begin
                col_trig[i] = |grid_word[CELL_W*i +: CELL_W];
                col_accm[i] = (grid_word[CELL_W*i +: CELL_W] == CELL_ACCENT);
            end
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                mul_a = $signed(MUL_A_W'(r_step_len));
                mul_b = $signed(MUL_B_W'(r_shuffle));
            end
            ST_SW1: begin
                mul_a = $signed({1'b0, prod[25:0]});
                mul_b = MUL_B_W'(SWING_NUM);
            end
            ST_SW2: begin
                mul_a = MUL_A_W'(r_drift_mem);
                mul_b = MUL_B_W'(DRIFT_KEEP);
            end
            ST_DR0: begin
                mul_a = MUL_A_W'(r_target);
                mul_b = MUL_B_W'(DRIFT_TAKE);
            end
            ST_DR2: begin
                mul_a = MUL_A_W'(r_drift_mem);
                mul_b = $signed(MUL_B_W'(r_spm));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // swing, drift filter, rounding and reload
    always_comb begin
        swing    = prod[SWING_SHIFT +: STEP_W];
        dr_sum   = r_sum + prod[31:0];
        dr_shift = dr_sum >>> 15;
        dr_m     = dr_shift[16:0];
        if (dr_m > 17'sd32767) begin
            n_drift_mem = 16'sh7FFF;
        end else if (dr_m < -17'sd32768) begin
            n_drift_mem = 16'sh8000;
        end else begin
            n_drift_mem = dr_m[DRIFT_W-1:0];
        end
        // round half away from zero
        dr_p        = prod[23:0];
        dr_mag      = dr_p[23] ? 24'(-dr_p) : 24'(dr_p);
        dr_rnd_full = {1'b0, dr_mag} + 25'(Q15_HALF);
        dr_rnd      = dr_rnd_full[24:15];
        n_dsamp     = dr_p[23] ? -$signed({1'b0, dr_rnd}) : $signed({1'b0, dr_rnd});
        n_reload    = r_base + 20'(r_dsamp);
        n_countdown = (n_reload < 20'sd1) ? CNT_W'(1) : n_reload[CNT_W-1:0];
        col_inc     = {1'b0, r_column} + (COL_W + 1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step_len  <= STEP_RESET;
            r_shuffle   <= SHUF_RESET;
            r_spm       <= SPM_RESET;
            r_countdown <= CNT_W'(STEP_RESET);
            r_column    <= '0;
            r_run       <= 1'b0;
            r_drift_mem <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_STEP_LENGTH: r_step_len <= i_cfg_data;
                    CFG_SHUFFLE:     r_shuffle  <= i_cfg_data[SHUF_W-1:0];
                    CFG_SAMPLES_MS:  r_spm      <= i_cfg_data[SPM_W-1:0];
                    default: ;
                endcase
            end

            // in ST_OUT the output register is reloaded below instead
            if (r_out_valid && !i_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_inst     <= i_instrument;
                        r_col      <= i_step_index;
                        r_val      <= i_cell_value;
                        r_target   <= i_drift_random;
                        r_edit_set <= (i_mode == MODE_SET);
                        r_fired    <= 1'b0;
                        r_trig     <= '0;
                        r_accm     <= '0;
                        r_fstep    <= '0;
                        unique case (i_mode)
                            MODE_TICK: begin
                                if (fire_now) begin
                                    r_state <= ST_SW1;
                                end else begin
                                    r_state <= ST_RB1;
                                    if (r_run) begin
                                        r_countdown <= r_countdown - CNT_W'(1);
                                    end
                                end
                            end
                            MODE_START: begin
                                r_run       <= 1'b1;
                                r_countdown <= CNT_W'(r_step_len);
                                r_column    <= '0;
                                r_drift_mem <= '0;
                                r_state     <= ST_RB1;
                            end
                            MODE_STOP: begin
                                r_run   <= 1'b0;
                                r_state <= ST_RB1;
                            end
                            MODE_SET, MODE_CYCLE: r_state <= ST_ED1;
                            default: r_state <= ST_RB1;
                        endcase
                    end
                end
                ST_SW1: begin
                    r_trig  <= col_trig;
                    r_accm  <= col_accm;
                    r_fired <= 1'b1;
                    r_fstep <= r_column;
                    r_state <= ST_SW2;
                end
                ST_SW2: begin
                    r_base  <= $signed(20'(r_step_len)) +
                               (r_column[0] ? $signed(20'(swing)) : 20'sd0);
                    r_dsamp <= '0;
                    r_state <= (r_column[1:0] == 2'd0) ? ST_DR0 : ST_LOAD;
                end
                ST_DR0: begin
                    r_sum   <= prod[31:0] + 32'sd16384;
                    r_state <= ST_DR1;
                end
                ST_DR1: begin
                    r_drift_mem <= n_drift_mem;
                    r_state     <= ST_DR2;
                end
                ST_DR2: r_state <= ST_DR3;
                ST_DR3: begin
                    r_dsamp <= n_dsamp;
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_countdown <= n_countdown;
                    r_column    <= (col_inc == (COL_W + 1)'(NUM_STEPS)) ? '0 : col_inc[COL_W-1:0];
                    r_state     <= ST_RB0;
                end
                ST_RB0: r_state <= ST_RB1;
                ST_RB1: begin
                    r_rdbk  <= addr_ok ? rd_cell : CELL_OFF;
                    r_state <= ST_OUT;
                end
                ST_ED1: begin
                    r_rdbk  <= addr_ok ? n_cell : CELL_OFF;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_fired <= r_fired;
                        r_out_trig  <= r_trig;
                        r_out_accm  <= r_accm;
                        r_out_fstep <= r_fstep;
                        r_out_rdbk  <= r_rdbk;
                        r_out_run   <= r_run;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_fired         = r_out_fired;
    assign o_trigger_mask  = r_out_trig;
    assign o_accent_mask   = r_out_accm;
    assign o_fired_step    = r_out_fstep;
    assign o_cell_readback = r_out_rdbk;
    assign o_is_running    = r_out_run;

    `DSS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, o_stall, "accept did not start work")
    `DSS_ASSERT(a_quiet_when_not_fired, i_clk, i_rst_n, o_valid && !o_fired, (o_trigger_mask == '0) && (o_accent_mask == '0) && (o_fired_step == '0), "masks set without a fire")
    `DSS_ASSERT(a_fire_while_running, i_clk, i_rst_n, o_valid && o_fired, o_is_running, "fired while stopped")
    `DSS_ASSERT(a_accent_is_trigger, i_clk, i_rst_n, o_valid, (o_accent_mask & ~o_trigger_mask) == '0, "accent without trigger")

endmodule
